// File: hdl/three_class_page_allocator_core_macros.svh
// Assertion macros for the three-class page allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef THREE_CLASS_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define THREE_CLASS_PAGE_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define TCPA_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TCPA_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TCPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCPA_ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define TCPA_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define TCPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hdl/tcpa_pkg.sv
// Shared types and constants for the three-class page allocator.
// No dependencies; imported by the allocator top level.
package tcpa_pkg;

    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W      = 1;
    localparam int CLASS_W   = 2;
    localparam int STATUS_W  = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CLASS_W-1:0]   cls_t;
    typedef logic [STATUS_W-1:0]  status_t;

    localparam cfg_idx_t CFG_FREE_FLOOR = 1'b0;
    localparam cfg_idx_t CFG_MEM_TOTAL  = 1'b1;

    localparam op_t OP_ALLOC = 1'b0;
    localparam op_t OP_FREE  = 1'b1;

    localparam cls_t CLS_SMALL  = 2'd0;
    localparam cls_t CLS_MEDIUM = 2'd1;
    localparam cls_t CLS_LARGE  = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_MEM  = 2'd1;
    localparam status_t ST_INVALID = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    // Block size of each class as a power of two.
    localparam int SHIFT_SMALL  = 12;
    localparam int SHIFT_MEDIUM = 19;
    localparam int SHIFT_LARGE  = 26;

    localparam int NUM_CLASSES = 3;
    localparam int SPLIT_WAYS  = 128;
    localparam int PIECE_W     = 7;

endpackage

// File: hdl/three_class_page_allocator_core.sv
// Top level of the three-class physical page allocator: sequencer, stack counts,
// range checks and result register. Depends on tcpa_pkg, tcpa_stack_ram and the macro header.
//
//  Channel   Direction  Handshake          Content
//  s_        in         s_tvalid/s_tready  request: op, size_class, addr
//  m_        out        m_tvalid/m_tready  result: block_addr, status
//  cfg_      in         cfg_we only        free_floor, mem_total
//
// A free, a bad size class or an out-of-memory allocate passes through the decode and
// result states; an allocate that reads a stack also passes the read state, which takes
// the registered read data of the stack memory. Only when the result register loads does
// the sequencer go back to idle and accept a new request. An allocate that splits a
// larger block also writes 127 pieces, one at a time, through the single write port of
// the stack memory, or 254 when a 64 MiB block feeds a 4 KiB request. Reset is
// synchronous and clears the stack counts, configuration registers, sequencer state and
// output valid; the stack memory needs no clearing pass. A stalled result is held while
// the next request is accepted; that request then waits for the result register to free up.
`include "three_class_page_allocator_core_macros.svh"

module three_class_page_allocator_core
    import tcpa_pkg::*;
#(
    parameter int ADDR_BITS  = 40,
    parameter int FREE_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Bits from low: op[0], size_class[2:1], addr[ADDR_BITS+2:3], zero pad.
    input  logic [((ADDR_BITS+10)/8)*8-1:0] s_tdata,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Bits from low: block_addr[ADDR_BITS-1:0], status[ADDR_BITS+1:ADDR_BITS], zero pad.
    output logic [((ADDR_BITS+9)/8)*8-1:0]  m_tdata,
    // Configuration writes.
    input  logic                           cfg_we,
    input  cfg_idx_t                       cfg_addr,
    input  logic [CFG_W-1:0]               cfg_wdata
);

    localparam int M_TDATA_W = ((ADDR_BITS + 9) / 8) * 8;
    localparam int IDX_W     = $clog2(FREE_DEPTH);
    localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_CLASSES * FREE_DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    // The small class has the longest page numbers, so it sets the memory width.
    localparam int ENT_W     = ADDR_BITS - SHIFT_SMALL;
    // Comparison width covers both address and register widths plus a carry bit.
    localparam int CMP_W     = ((ADDR_BITS > CFG_W) ? ADDR_BITS : CFG_W) + 1;

    localparam logic [RAM_AW-1:0] OFF_MEDIUM = RAM_AW'(FREE_DEPTH);
    localparam logic [RAM_AW-1:0] OFF_LARGE  = RAM_AW'(2 * FREE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(FREE_DEPTH);
    localparam logic [PIECE_W-1:0] PIECE_TOP = PIECE_W'(SPLIT_WAYS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SPLIT,
        S_RESULT
    } state_t;

    // What the stack read issued in S_DECODE is for.
    typedef enum logic [1:0] {
        M_POP,
        M_SPLIT_MED,
        M_SPLIT_LARGE
    } mode_t;

    state_t             state_reg;
    mode_t              mode_reg;
    op_t                op_reg;
    cls_t               cls_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    cls_t               src_reg;
    cls_t               tgt_reg;
    logic               small_after_reg;
    logic [PIECE_W-1:0] piece_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] res_addr_reg;
    status_t            res_status_reg;

    logic [CNT_W-1:0]   cnt_small_reg;
    logic [CNT_W-1:0]   cnt_medium_reg;
    logic [CNT_W-1:0]   cnt_large_reg;
    logic [CFG_W-1:0]   free_floor_reg;
    logic [CFG_W-1:0]   mem_total_reg;

    logic               m_tvalid_reg;
    logic [ADDR_BITS-1:0] m_addr_reg;
    status_t            m_status_reg;

    // Helper functions for per-class selection and address arithmetic.

    function automatic logic [CNT_W-1:0] cnt_of(input cls_t c, input logic [CNT_W-1:0] cs,
                                                input logic [CNT_W-1:0] cm,
                                                input logic [CNT_W-1:0] cl);
        logic [CNT_W-1:0] r;
        case (c)
            CLS_SMALL:  r = cs;
            CLS_MEDIUM: r = cm;
            CLS_LARGE:  r = cl;
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [RAM_AW-1:0] ram_addr(input cls_t c, input logic [IDX_W-1:0] idx);
        logic [RAM_AW-1:0] off;
        case (c)
            CLS_MEDIUM: off = OFF_MEDIUM;
            CLS_LARGE:  off = OFF_LARGE;
            default:    off = '0;
        endcase
        return off + RAM_AW'(idx);
    endfunction

    // Clear the address bits below the class block size.
    function automatic logic [ADDR_BITS-1:0] align(input cls_t c, input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS-1:0] r;
        case (c)
            CLS_SMALL:  r = {a[ADDR_BITS-1:SHIFT_SMALL], {SHIFT_SMALL{1'b0}}};
            CLS_MEDIUM: r = {a[ADDR_BITS-1:SHIFT_MEDIUM], {SHIFT_MEDIUM{1'b0}}};
            CLS_LARGE:  r = {a[ADDR_BITS-1:SHIFT_LARGE], {SHIFT_LARGE{1'b0}}};
            default:    r = a;
        endcase
        return r;
    endfunction

    // Page number of an address in a class, as stored in the stack memory.
    function automatic logic [ENT_W-1:0] page_of(input cls_t c, input logic [ADDR_BITS-1:0] a);
        logic [ENT_W-1:0] r;
        case (c)
            CLS_SMALL:  r = a[ADDR_BITS-1:SHIFT_SMALL];
            CLS_MEDIUM: r = ENT_W'(a[ADDR_BITS-1:SHIFT_MEDIUM]);
            CLS_LARGE:  r = ENT_W'(a[ADDR_BITS-1:SHIFT_LARGE]);
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] addr_of(input cls_t c, input logic [ENT_W-1:0] p);
        logic [ADDR_BITS-1:0] r;
        case (c)
            CLS_SMALL:  r = {p, {SHIFT_SMALL{1'b0}}};
            CLS_MEDIUM: r = {p[ADDR_BITS-SHIFT_MEDIUM-1:0], {SHIFT_MEDIUM{1'b0}}};
            CLS_LARGE:  r = {p[ADDR_BITS-SHIFT_LARGE-1:0], {SHIFT_LARGE{1'b0}}};
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic range_ok(input logic [CMP_W-1:0] lo, input logic [CMP_W-1:0] hi,
                                      input logic [CFG_W-1:0] kend,
                                      input logic [CFG_W-1:0] mtot);
        return (lo != '0) && (lo >= CMP_W'(kend)) && (hi < CMP_W'(mtot));
    endfunction

    // Stack memory interface.
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    tcpa_stack_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (RAM_AW)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Decode of the latched request. Everything here depends only on the request, the stack
    // counts and the configuration registers, so it is evaluated in S_DECODE.
    logic [CNT_W-1:0]     cnt_cls;
    logic [ADDR_BITS-1:0] free_aligned;
    logic                 free_ok;
    logic                 dec_read;
    logic                 dec_write;
    cls_t                 dec_src;
    mode_t                dec_mode;
    status_t              dec_status;
    logic [CNT_W-1:0]     rd_cnt;
    logic [CNT_W-1:0]     rd_cnt_m1;

    assign cnt_cls      = cnt_of(cls_reg, cnt_small_reg, cnt_medium_reg, cnt_large_reg);
    assign free_aligned = align(cls_reg, addr_reg);
    assign free_ok      = range_ok(CMP_W'(free_aligned), CMP_W'(free_aligned),
                                   free_floor_reg, mem_total_reg);

    always_comb begin
        dec_read   = 1'b0;
        dec_write  = 1'b0;
        dec_src    = cls_reg;
        dec_mode   = M_POP;
        dec_status = ST_OK;
        if (cls_reg != CLS_SMALL && cls_reg != CLS_MEDIUM && cls_reg != CLS_LARGE) begin
            dec_status = ST_INVALID;
        end else if (op_reg == OP_FREE) begin
            // The address check wins over a full stack.
            if (!free_ok) begin
                dec_status = ST_INVALID;
            end else if (cnt_cls >= CNT_FULL) begin
                dec_status = ST_FULL;
            end else begin
                dec_write = 1'b1;
            end
        end else if (cnt_cls != '0) begin
            dec_read = 1'b1;
        end else if (cls_reg == CLS_LARGE) begin
            dec_status = ST_NO_MEM;
        end else if (cls_reg == CLS_SMALL && cnt_medium_reg != '0) begin
            dec_read = 1'b1;
            dec_src  = CLS_MEDIUM;
            dec_mode = M_SPLIT_MED;
        end else if (cnt_large_reg == '0) begin
            dec_status = ST_NO_MEM;
        end else begin
            dec_read = 1'b1;
            dec_src  = CLS_LARGE;
            dec_mode = M_SPLIT_LARGE;
        end
    end

    assign rd_cnt    = cnt_of(dec_src, cnt_small_reg, cnt_medium_reg, cnt_large_reg);
    assign rd_cnt_m1 = rd_cnt - CNT_W'(1);

    // Top entry returned by the memory in S_READ, and the split range check.
    // The span of a split is 127 pieces of the class just below the source.
    logic [ADDR_BITS-1:0] top_addr;
    logic [CMP_W-1:0]     split_span;
    logic [CMP_W-1:0]     split_hi;
    logic                 split_ok;

    assign top_addr = addr_of(src_reg, ram_rdata);

    always_comb begin
        case (src_reg)
            CLS_MEDIUM: split_span = CMP_W'(SPLIT_WAYS - 1) << SHIFT_SMALL;
            CLS_LARGE:  split_span = CMP_W'(SPLIT_WAYS - 1) << SHIFT_MEDIUM;
            default:    split_span = '0;
        endcase
    end

    assign split_hi = CMP_W'(top_addr) + split_span;
    assign split_ok = range_ok(CMP_W'(top_addr), split_hi, free_floor_reg, mem_total_reg);

    // Memory accesses. Reads are issued only from S_DECODE and writes only from
    // S_DECODE or S_SPLIT, and a request finishes all of its writes before the next
    // one decodes, so a read never overlaps a pending write to the same entry.
    logic [CNT_W-1:0] cnt_tgt;

    assign cnt_tgt = cnt_of(tgt_reg, cnt_small_reg, cnt_medium_reg, cnt_large_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ram_addr(cls_reg, cnt_cls[IDX_W-1:0]);
        ram_wdata = page_of(cls_reg, free_aligned);
        if (state_reg == S_DECODE) begin
            ram_we = dec_write;
        end else if (state_reg == S_SPLIT) begin
            // The base is aligned to the larger class, so the piece number lands in
            // the low bits of the page number.
            ram_we    = 1'b1;
            ram_waddr = ram_addr(tgt_reg, cnt_tgt[IDX_W-1:0]);
            ram_wdata = page_of(tgt_reg, base_reg) + ENT_W'(piece_reg);
        end
    end

    assign ram_re    = (state_reg == S_DECODE) && dec_read;
    assign ram_raddr = ram_addr(dec_src, rd_cnt_m1[IDX_W-1:0]);

    // Stack count updates: a push increments, a pop decrements, never both at once.
    logic cnt_inc;
    cls_t cnt_inc_cls;
    logic cnt_dec;

    assign cnt_inc     = ram_we;
    assign cnt_inc_cls = (state_reg == S_SPLIT) ? tgt_reg : cls_reg;
    assign cnt_dec     = (state_reg == S_READ) && ((mode_reg == M_POP) || split_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_small_reg  <= '0;
            cnt_medium_reg <= '0;
            cnt_large_reg  <= '0;
        end else begin
            if (cnt_inc) begin
                case (cnt_inc_cls)
                    CLS_SMALL:  cnt_small_reg  <= cnt_small_reg + CNT_W'(1);
                    CLS_MEDIUM: cnt_medium_reg <= cnt_medium_reg + CNT_W'(1);
                    CLS_LARGE:  cnt_large_reg  <= cnt_large_reg + CNT_W'(1);
                    default:    ;
                endcase
            end
            if (cnt_dec) begin
                case (src_reg)
                    CLS_SMALL:  cnt_small_reg  <= cnt_small_reg - CNT_W'(1);
                    CLS_MEDIUM: cnt_medium_reg <= cnt_medium_reg - CNT_W'(1);
                    CLS_LARGE:  cnt_large_reg  <= cnt_large_reg - CNT_W'(1);
                    default:    ;
                endcase
            end
        end
    end

    // Configuration registers. User writes only while the block is idle; not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_floor_reg <= '0;
            mem_total_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FREE_FLOOR: free_floor_reg <= cfg_wdata;
                CFG_MEM_TOTAL:  mem_total_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    logic s_accept;
    logic out_free;
    logic split_last;

    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign split_last = (piece_reg == PIECE_W'(1));

    // Sequencer and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    state_reg <= dec_read ? S_READ : S_RESULT;
                end
                S_READ: begin
                    if (mode_reg != M_POP && split_ok) begin
                        state_reg <= S_SPLIT;
                    end else begin
                        state_reg <= S_RESULT;
                    end
                end
                S_SPLIT: begin
                    if (split_last && !small_after_reg) begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; they follow the sequencer and need no reset.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_reg   <= s_tdata[0];
                    cls_reg  <= s_tdata[2:1];
                    addr_reg <= s_tdata[ADDR_BITS+2:3];
                end
            end
            S_DECODE: begin
                src_reg        <= dec_src;
                mode_reg       <= dec_mode;
                res_addr_reg   <= '0;
                res_status_reg <= dec_status;
            end
            S_READ: begin
                if (mode_reg == M_POP) begin
                    res_addr_reg   <= top_addr;
                    res_status_reg <= ST_OK;
                end else if (!split_ok) begin
                    res_addr_reg   <= '0;
                    res_status_reg <= ST_INVALID;
                end else begin
                    // The lowest piece is handed out; the upper ones are pushed
                    // from the highest down, so the lowest pops first later on.
                    res_addr_reg    <= top_addr;
                    res_status_reg  <= ST_OK;
                    base_reg        <= top_addr;
                    tgt_reg         <= (mode_reg == M_SPLIT_LARGE) ? CLS_MEDIUM : CLS_SMALL;
                    small_after_reg <= (mode_reg == M_SPLIT_LARGE) && (cls_reg == CLS_SMALL);
                    piece_reg       <= PIECE_TOP;
                end
            end
            S_SPLIT: begin
                if (split_last) begin
                    // A 4 KiB request fed from a 64 MiB block also splits the
                    // lowest 512 KiB piece into 4 KiB pieces.
                    if (small_after_reg) begin
                        tgt_reg         <= CLS_SMALL;
                        small_after_reg <= 1'b0;
                        piece_reg       <= PIECE_TOP;
                    end
                end else begin
                    piece_reg <= piece_reg - PIECE_W'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_addr_reg   <= res_addr_reg;
                    m_status_reg <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_status_reg, m_addr_reg});

    // Assertions.
    logic cnt_in_range;
    logic m_fail;
    logic m_addr_zero;
    logic in_split;
    logic tgt_room;
    logic in_decode;

    assign cnt_in_range = (cnt_small_reg <= CNT_FULL) && (cnt_medium_reg <= CNT_FULL) &&
                          (cnt_large_reg <= CNT_FULL);
    assign m_fail       = m_tvalid_reg && (m_status_reg != ST_OK);
    assign m_addr_zero  = (m_addr_reg == '0);
    assign in_split     = (state_reg == S_SPLIT);
    assign tgt_room     = (cnt_tgt < CNT_FULL);
    assign in_decode    = (state_reg == S_DECODE) && !s_tready;

    `TCPA_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_in_range, "stack count exceeds depth")
    `TCPA_ASSERT_IMPLIES(a_fail_zero, aclk, aresetn, m_fail, m_addr_zero, "failed with address")
    `TCPA_ASSERT_IMPLIES(a_pop_nonempty, aclk, aresetn, ram_re, rd_cnt != '0, "empty stack read")
    `TCPA_ASSERT_IMPLIES(a_split_room, aclk, aresetn, in_split, tgt_room, "split into full stack")
    `TCPA_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_accept, in_decode, "request not decoded")

endmodule

// File: hdl/tcpa_stack_ram.sv
// Simple dual-port RAM holding the free stacks of all size classes.
// One write and one registered read per cycle; no package dependencies.
module tcpa_stack_ram #(
    parameter int DATA_W = 28,
    parameter int DEPTH  = 3072,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
